// ----- hw/rtl/bdcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcg_pkg
// Shared types, constants and constant functions of the demosaic pipeline.
// ----------------------------------------------------------------------------
package bdcg_pkg;

  localparam int PixW   = 8;
  localparam int PairsW = 11;

  // configuration register indexes
  localparam logic CFG_WIDTH_PAIRS  = 1'b0;
  localparam logic CFG_HEIGHT_PAIRS = 1'b1;

  localparam logic [PairsW-1:0] WIDTH_PAIRS_RST  = 11'd320;
  localparam logic [PairsW-1:0] HEIGHT_PAIRS_RST = 11'd240;

  // color matrix in hundredths, row major
  localparam int CCM_HUNDREDTHS [9] = '{118, -9, -13, -24, 119, -5, -18, -44, 171};

  // 3x3 neighborhood row: index 0 = left, 1 = center, 2 = right
  typedef logic [2:0][PixW-1:0] pix3_t;

  typedef struct packed {
    logic row_odd;
    logic col_odd;
    logic top;
    logic bot;
    logic left;
    logic right;
  } site_t;

  typedef struct packed {
    logic line_end;
    logic frame_end;
  } pix_flags_t;

  typedef struct packed {
    logic [PixW-1:0] r;
    logic [PixW-1:0] g;
    logic [PixW-1:0] b;
  } rgb_t;

  // q-format coefficient, rounded half away from zero
  function automatic int ccm_coef(int k, int frac);
    longint h;
    longint one;
    longint q;
    h   = longint'(CCM_HUNDREDTHS[k]);
    one = longint'(1) << frac;
    if (h < 0) begin
      q = -(((-h) * one + 50) / 100);
    end else begin
      q = (h * one + 50) / 100;
    end
    return int'(q);
  endfunction

  // floor(s / 3) for s up to 765 by reciprocal multiply
  function automatic logic [PixW-1:0] div3(logic [9:0] s);
    logic [20:0] p;
    p = {11'd0, s} * 21'd683;
    return p[18:11];
  endfunction

  function automatic logic [PixW-1:0] avg2(logic [PixW-1:0] a, logic [PixW-1:0] b);
    logic [PixW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PixW:1];
  endfunction

  function automatic logic [PixW-1:0] avg3(logic [PixW-1:0] a, logic [PixW-1:0] b,
                                            logic [PixW-1:0] c);
    logic [9:0] s;
    s = {2'b0, a} + {2'b0, b} + {2'b0, c};
    return div3(s);
  endfunction

  function automatic logic [PixW-1:0] avg4(logic [PixW-1:0] a, logic [PixW-1:0] b,
                                            logic [PixW-1:0] c, logic [PixW-1:0] d);
    logic [9:0] s;
    s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
    return s[9:2];
  endfunction

  // floor(sqrt(255 * v)), evaluated only with constant arguments
  function automatic logic [PixW-1:0] gamma_calc(int v);
    int n;
    int r;
    n = 255 * v;
    r = 0;
    for (int s = 0; s < 256; s++) begin
      if ((s + 1) * (s + 1) <= n) begin
        r = s + 1;
      end
    end
    return PixW'(r);
  endfunction

endpackage

// ----- hw/rtl/bdcg_interp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcg_interp
// Bilinear interpolation of the missing colors at one GRBG site.
// ----------------------------------------------------------------------------
module bdcg_interp (
  input  bdcg_pkg::pix3_t t_i,
  input  bdcg_pkg::pix3_t m_i,
  input  bdcg_pkg::pix3_t b_i,
  input  bdcg_pkg::site_t site_i,
  output bdcg_pkg::rgb_t  rgb_o
);
  import bdcg_pkg::*;

  always_comb begin
    rgb_o = '0;
    if (!site_i.row_odd) begin
      if (!site_i.col_odd) begin
        // green on a green/red row
        rgb_o.b = site_i.top ? b_i[1] : avg2(t_i[1], b_i[1]);
        rgb_o.r = site_i.left ? m_i[2] : avg2(m_i[0], m_i[2]);
        rgb_o.g = m_i[1];
      end else begin
        if (site_i.right) begin
          if (site_i.top) begin
            rgb_o.g = avg2(m_i[0], b_i[1]);
            rgb_o.b = b_i[0];
          end else begin
            rgb_o.g = avg3(t_i[1], m_i[0], b_i[1]);
            rgb_o.b = avg2(t_i[0], b_i[0]);
          end
        end else begin
          if (site_i.top) begin
            rgb_o.g = avg3(m_i[0], m_i[2], b_i[1]);
            rgb_o.b = avg2(b_i[0], b_i[2]);
          end else begin
            rgb_o.g = avg4(t_i[1], b_i[1], m_i[0], m_i[2]);
            rgb_o.b = avg4(t_i[0], t_i[2], b_i[2], b_i[0]);
          end
        end
        rgb_o.r = m_i[1];
      end
    end else begin
      if (!site_i.col_odd) begin
        if (site_i.left) begin
          if (site_i.bot) begin
            rgb_o.r = t_i[2];
            rgb_o.g = avg2(t_i[1], m_i[2]);
          end else begin
            rgb_o.r = avg2(t_i[2], b_i[2]);
            rgb_o.g = avg3(t_i[1], b_i[1], m_i[2]);
          end
        end else begin
          if (site_i.bot) begin
            rgb_o.r = avg2(t_i[0], t_i[2]);
            rgb_o.g = avg3(m_i[0], m_i[2], t_i[1]);
          end else begin
            rgb_o.r = avg4(t_i[0], t_i[2], b_i[2], b_i[0]);
            rgb_o.g = avg4(t_i[1], b_i[1], m_i[0], m_i[2]);
          end
        end
        rgb_o.b = m_i[1];
      end else begin
        // green on a blue/green row
        rgb_o.r = site_i.bot ? t_i[1] : avg2(t_i[1], b_i[1]);
        rgb_o.b = site_i.right ? m_i[0] : avg2(m_i[0], m_i[2]);
        rgb_o.g = m_i[1];
      end
    end
  end

endmodule

// ----- hw/rtl/bdcg_ccm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcg_ccm
// 3x3 color matrix with floor and clamp to 0..255, registered result.
// ----------------------------------------------------------------------------
module bdcg_ccm #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   load_i,
  input  bdcg_pkg::rgb_t         rgb_i,
  input  bdcg_pkg::pix_flags_t   flags_i,
  output bdcg_pkg::rgb_t         rgb_o,
  output bdcg_pkg::pix_flags_t   flags_o
);
  import bdcg_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = CW + PixW + 1;
  localparam int AW = PW + 2;

  logic signed [PixW:0]   chan   [3];
  logic signed [AW-1:0]   acc    [3];
  logic signed [AW-1:0]   shr    [3];
  logic [PixW-1:0]        v      [3];
  rgb_t                   rgb_q;
  pix_flags_t             flags_q;

  assign chan[0] = $signed({1'b0, rgb_i.r});
  assign chan[1] = $signed({1'b0, rgb_i.g});
  assign chan[2] = $signed({1'b0, rgb_i.b});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = '0;
      for (int j = 0; j < 3; j++) begin
        acc[i] = acc[i] + AW'($signed(CW'(ccm_coef(i * 3 + j, COEF_FRAC_BITS))))
                        * AW'(chan[j]);
      end
      shr[i] = acc[i] >>> COEF_FRAC_BITS;
      if (acc[i] < 0) begin
        v[i] = '0;
      end else if (shr[i] > AW'(255)) begin
        v[i] = 8'd255;
      end else begin
        v[i] = shr[i][PixW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rgb_q   <= '{r: v[0], g: v[1], b: v[2]};
      flags_q <= flags_i;
    end
  end

  assign rgb_o   = rgb_q;
  assign flags_o = flags_q;

endmodule

// ----- hw/rtl/bdcg_gamma.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcg_gamma
// Gamma 0.5 lookup per channel into the output register.
// ----------------------------------------------------------------------------
module bdcg_gamma (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  bdcg_pkg::rgb_t       rgb_i,
  input  bdcg_pkg::pix_flags_t flags_i,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic                 line_end_o,
  output logic                 frame_end_o
);
  import bdcg_pkg::*;

  logic [PixW-1:0] rom [256];
  rgb_t            out_q;
  pix_flags_t      flags_q;

  for (genvar i = 0; i < 256; i++) begin : g_rom
    assign rom[i] = gamma_calc(i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q   <= '{r: rom[rgb_i.r], g: rom[rgb_i.g], b: rom[rgb_i.b]};
      flags_q <= flags_i;
    end
  end

  assign red_o       = out_q.r;
  assign green_o     = out_q.g;
  assign blue_o      = out_q.b;
  assign line_end_o  = flags_q.line_end;
  assign frame_end_o = flags_q.frame_end;

endmodule

// ----- hw/rtl/bayer_demosaic_ccm_gamma_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_demosaic_ccm_gamma_top
// GRBG bilinear demosaic, color matrix and gamma, one raw sample per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | raw_pixel_i, drain_i
//  out     | out_valid_o/ out_stall_i| red_o, green_o, blue_o, line_end_o, frame_end_o
//  cfg     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// one transaction per cycle when neither side stalls; the last sample of a row
// yields two pixels and holds the input stage until the second one is pushed
// (not in the first row, which emits nothing). a pixel passes the interpolation
// register, the color matrix register and the gamma output register in turn,
// the second pixel of a row end right behind the first. the line store is a
// single MAX_WIDTH deep memory, no clearing pass after reset.
// out_stall_i backs up through the stage valid bits to in_stall_o.
// ----------------------------------------------------------------------------
module bayer_demosaic_ccm_gamma_top #(
  parameter int MAX_WIDTH      = 2048,
  parameter int MAX_HEIGHT     = 2048,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  raw_pixel_i,
  input  logic        drain_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        line_end_o,
  output logic        frame_end_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  import bdcg_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [PairsW-1:0] width_pairs_q, height_pairs_q;
  logic [WW-1:0]     w_eff;
  logic [RW-1:0]     h_eff;

  logic [XW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic              in_acc, row_end;

  logic [2*PixW-1:0] line_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_q;

  logic              s1_valid_q, s1_phase_q;
  logic              s1_emit_q, s1_two_q, s1_rodd_q, s1_codd_q;
  logic              s1_top_q, s1_bot_q, s1_left_q, s1_right_q;
  logic [XW-1:0]     s1_x_q;
  logic [PixW-1:0]   s1_sample_q;
  logic              s1_push, s1_retire, s1_ready;

  logic [PixW-1:0]   win_q [6];
  pix3_t             t_sel, m_sel, b_sel;
  site_t             site_sel;
  pix_flags_t        flags_sel;
  rgb_t              rgb_int;

  logic              s2_valid_q, s2_ready;
  rgb_t              s2_rgb_q;
  pix_flags_t        s2_flags_q;
  logic              s3_valid_q, s3_ready;
  rgb_t              s3_rgb;
  pix_flags_t        s3_flags;
  logic              s4_valid_q, s4_ready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_pairs_q  <= WIDTH_PAIRS_RST;
      height_pairs_q <= HEIGHT_PAIRS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH_PAIRS:  width_pairs_q  <= cfg_data_i;
        CFG_HEIGHT_PAIRS: height_pairs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_pairs_q == '0) begin
      w_eff = WW'(2);
    end else if (32'(width_pairs_q) > 32'(MAX_WIDTH / 2)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'({width_pairs_q, 1'b0});
    end
    if (height_pairs_q == '0) begin
      h_eff = RW'(2);
    end else if (32'(height_pairs_q) > 32'(MAX_HEIGHT / 2)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'({height_pairs_q, 1'b0});
    end
  end

  // handshake chain
  assign s4_ready  = !s4_valid_q || !out_stall_i;
  assign s3_ready  = !s3_valid_q || s4_ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_push   = s1_valid_q && s1_emit_q && s2_ready;
  assign s1_retire = s1_valid_q && (!s1_emit_q || (s2_ready && (!s1_two_q || s1_phase_q)));
  assign s1_ready  = !s1_valid_q || s1_retire;
  assign in_stall_o = !s1_ready;
  assign in_acc    = in_valid_i && s1_ready;
  assign out_valid_o = s4_valid_q;

  // input position
  assign row_end = (32'(col_q) + 32'd1) >= 32'(w_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (row_end) begin
        col_d = '0;
        row_d = (32'(row_q) >= 32'(h_eff)) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store entry holds {upper, middle}
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_retire) begin
      line_mem[s1_x_q] <= {rd_q[PixW-1:0], s1_sample_q};
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_phase_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
        s1_phase_q <= 1'b0;
      end else if (s1_push) begin
        s1_phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q      <= col_q;
      s1_sample_q <= drain_i ? '0 : raw_pixel_i;
      s1_emit_q   <= (row_q != '0) && (col_q != '0);
      s1_two_q    <= row_end;
      s1_rodd_q   <= !row_q[0];
      s1_codd_q   <= !col_q[0];
      s1_top_q    <= row_q == RW'(1);
      s1_bot_q    <= 32'(row_q) >= 32'(h_eff);
      s1_left_q   <= col_q == XW'(1);
      s1_right_q  <= 32'(col_q) >= 32'(w_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_retire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= rd_q[2*PixW-1:PixW];
      win_q[4] <= rd_q[PixW-1:0];
      win_q[5] <= s1_sample_q;
    end
  end

  // second pixel of a row end sits one column right, past the edge
  always_comb begin
    if (!s1_phase_q) begin
      t_sel = {rd_q[2*PixW-1:PixW], win_q[3], win_q[0]};
      m_sel = {rd_q[PixW-1:0], win_q[4], win_q[1]};
      b_sel = {s1_sample_q, win_q[5], win_q[2]};
      site_sel = '{row_odd: s1_rodd_q, col_odd: s1_codd_q, top: s1_top_q, bot: s1_bot_q,
                   left: s1_left_q, right: s1_right_q};
      flags_sel = '{line_end: 1'b0, frame_end: 1'b0};
    end else begin
      t_sel = {{PixW{1'b0}}, rd_q[2*PixW-1:PixW], win_q[3]};
      m_sel = {{PixW{1'b0}}, rd_q[PixW-1:0], win_q[4]};
      b_sel = {{PixW{1'b0}}, s1_sample_q, win_q[5]};
      site_sel = '{row_odd: s1_rodd_q, col_odd: !s1_codd_q, top: s1_top_q, bot: s1_bot_q,
                   left: 1'b0, right: 1'b1};
      flags_sel = '{line_end: 1'b1, frame_end: s1_bot_q};
    end
  end

  bdcg_interp u_interp (
    .t_i    (t_sel),
    .m_i    (m_sel),
    .b_i    (b_sel),
    .site_i (site_sel),
    .rgb_o  (rgb_int)
  );

  always_ff @(posedge clk_i) begin
    if (s1_push) begin
      s2_rgb_q   <= rgb_int;
      s2_flags_q <= flags_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_push;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  bdcg_ccm #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_ccm (
    .clk_i   (clk_i),
    .load_i  (s3_ready && s2_valid_q),
    .rgb_i   (s2_rgb_q),
    .flags_i (s2_flags_q),
    .rgb_o   (s3_rgb),
    .flags_o (s3_flags)
  );

  bdcg_gamma u_gamma (
    .clk_i       (clk_i),
    .load_i      (s4_ready && s3_valid_q),
    .rgb_i       (s3_rgb),
    .flags_i     (s3_flags),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .line_end_o  (line_end_o),
    .frame_end_o (frame_end_o)
  );

`ifndef SYNTHESIS
  a_phase_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_phase_q |-> (s1_valid_q && s1_two_q && s1_emit_q))
    else $error("second-pixel phase without a row-end item");

  a_phase_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_phase_q && s2_ready) |=> !s1_phase_q)
    else $error("second pixel not pushed when downstream had room");

  a_frame_end_on_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!frame_end_o || line_end_o))
    else $error("frame end without line end");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && row_end) |=> (col_q == '0))
    else $error("column did not wrap at row end");
`endif

endmodule
